FILE: src/lsra_pkg.sv
// ----------------------------------------------------------------------------
// Linear scan register assignment package
// Shared payload types, field widths, action codes and default sizes.
// ----------------------------------------------------------------------------
package lsra_pkg;

    // Field widths of the request and response items.
    localparam int POS_W   = 16;
    localparam int LOC_W   = 10;
    localparam int MASK_W  = 5;
    localparam int SPILL_W = 11;

    // Number of spill slots per function; the counter saturates here.
    localparam int SPILL_SLOTS = 1024;

    // Default pool sizes.
    localparam int DEF_INT_REGS         = 7;
    localparam int DEF_INT_CALLEE_FIRST = 2;
    localparam int DEF_FLOAT_REGS       = 7;

    // Request action codes.
    localparam logic ACTION_ALLOCATE = 1'b0;
    localparam logic ACTION_CLEAR    = 1'b1;

    // One live interval, or a clear request.
    typedef struct packed {
        logic                    action;
        logic signed [POS_W-1:0] interval_start;
        logic signed [POS_W-1:0] interval_end;
        logic                    is_float;
        logic                    spans_call;
    } t_req;

    // One assignment result.
    typedef struct packed {
        logic               in_register;
        logic [LOC_W-1:0]   location_index;
        logic               float_pool;
        logic [MASK_W-1:0]  callee_saved_mask;
        logic [SPILL_W-1:0] spill_total;
        logic               spill_overflow;
    } t_rsp;

    // Control from the top level to one register pool.
    typedef struct packed {
        logic step;         // an allocate request is processed this cycle
        logic clear;        // a clear request is processed this cycle
        logic take;         // the interval may take a register of this pool
        logic callee_only;  // search only from the callee-saved floor upward
    } t_pool_ctl;

endpackage

FILE: src/lsra_pool.sv
// ----------------------------------------------------------------------------
// Linear scan register pool
// Busy bits and holder ends of one register file, with release of expired
// holders and a lowest-free-register search in the same cycle.
// ----------------------------------------------------------------------------
module lsra_pool #(
    parameter int NUM_REGS     = lsra_pkg::DEF_INT_REGS,
    parameter int SEARCH_FLOOR = 0,
    parameter int IDX_W        = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lsra_pkg::t_pool_ctl                 i_ctl,
    input  logic signed [lsra_pkg::POS_W-1:0]   i_start,
    input  logic signed [lsra_pkg::POS_W-1:0]   i_end,
    output logic                                o_found,
    output logic [IDX_W-1:0]                    o_index
);
    import lsra_pkg::*;

    logic [NUM_REGS-1:0]             r_busy;
    logic [NUM_REGS-1:0]             n_busy;
    logic signed [POS_W-1:0]         r_end [NUM_REGS];
    logic [NUM_REGS-1:0]             live;
    logic [NUM_REGS-1:0]             eligible;
    logic [NUM_REGS-1:0]             grant;
    logic                            any_free;

    // A register stays held only while its holder ends at or after the start.
    always_comb begin
        for (int k = 0; k < NUM_REGS; k++) begin
            live[k]     = r_busy[k] && !(r_end[k] < i_start);
            eligible[k] = !live[k] && (!i_ctl.callee_only || k >= SEARCH_FLOOR);
        end
    end

    // Lowest eligible register wins.
    always_comb begin
        any_free = 1'b0;
        o_index  = '0;
        for (int k = NUM_REGS - 1; k >= 0; k--) begin
            if (eligible[k]) begin
                any_free = 1'b1;
                o_index  = IDX_W'(k);
            end
        end
        o_found = i_ctl.take && any_free;
    end

    // Next busy bits: released set plus the newly granted register.
    always_comb begin
        for (int k = 0; k < NUM_REGS; k++) begin
            grant[k] = o_found && (int'(o_index) == k);
        end
        n_busy = live | grant;
    end

    // Busy bits are control state and clear on reset or a clear request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else if (i_ctl.clear) begin
            r_busy <= '0;
        end else if (i_ctl.step) begin
            r_busy <= n_busy;
        end
    end

    // Holder ends are only read while the matching busy bit is set.
    always_ff @(posedge i_clk) begin
        if (i_ctl.step && o_found) begin
            r_end[o_index] <= i_end;
        end
    end

endmodule

FILE: src/linear_scan_register_assign.sv
// ----------------------------------------------------------------------------
// Linear scan register assignment
// Places live intervals, sorted by start, into integer or float registers or
// spill slots, and reports per-function totals on a clear request.
// ----------------------------------------------------------------------------
// The block accepts one request per clock cycle while the response register
// is empty or being taken, and returns one response for each, in order. A
// request is captured in an input register and resolved once the response
// register can take it: release of expired holders, the lowest-free register
// search in both pools and the spill count all complete together and load the
// response register. Throughput is one interval per cycle unless the response
// side stalls. Requests keep flowing while a response waits, as long as the
// response register is taken or empty. A clear request returns the
// callee-saved mask and spill total of the finished function and then resets
// the pools, mask and spill counter.
module linear_scan_register_assign #(
    parameter int INT_REGS         = lsra_pkg::DEF_INT_REGS,
    parameter int INT_CALLEE_FIRST = lsra_pkg::DEF_INT_CALLEE_FIRST,
    parameter int FLOAT_REGS       = lsra_pkg::DEF_FLOAT_REGS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  lsra_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output lsra_pkg::t_rsp o_rsp
);
    import lsra_pkg::*;

    localparam int INT_IDX_W   = (INT_REGS > 1) ? $clog2(INT_REGS) : 1;
    localparam int FLOAT_IDX_W = (FLOAT_REGS > 1) ? $clog2(FLOAT_REGS) : 1;

    logic                   r_req_vld;
    t_req                   r_req;
    logic                   r_rsp_vld;
    t_rsp                   r_rsp;
    t_rsp                   n_rsp;
    logic [MASK_W-1:0]      r_callee;
    logic [MASK_W-1:0]      n_callee;
    logic [SPILL_W-1:0]     r_spill;
    logic [SPILL_W-1:0]     n_spill;
    logic                   proc_fire;
    logic                   is_alloc;
    logic                   is_clear;
    t_pool_ctl              int_ctl;
    t_pool_ctl              float_ctl;
    logic                   int_found;
    logic [INT_IDX_W-1:0]   int_idx;
    logic                   float_found;
    logic [FLOAT_IDX_W-1:0] float_idx;

    // The held request is resolved when the response register can take it.
    assign proc_fire   = r_req_vld && (!r_rsp_vld || i_rsp_ready);
    assign o_req_ready = !r_req_vld || proc_fire;
    assign is_alloc    = proc_fire && (r_req.action == ACTION_ALLOCATE);
    assign is_clear    = proc_fire && (r_req.action == ACTION_CLEAR);

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else if (o_req_ready) begin
            r_req_vld <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_ready && i_req_valid) begin
            r_req <= i_req;
        end
    end

    // Pool control: both pools release on every allocate request.
    always_comb begin
        int_ctl.step        = is_alloc;
        int_ctl.clear       = is_clear;
        int_ctl.take        = !r_req.is_float;
        int_ctl.callee_only = r_req.spans_call;

        float_ctl.step        = is_alloc;
        float_ctl.clear       = is_clear;
        float_ctl.take        = r_req.is_float && !r_req.spans_call;
        float_ctl.callee_only = 1'b0;
    end

    lsra_pool #(
        .NUM_REGS     (INT_REGS),
        .SEARCH_FLOOR (INT_CALLEE_FIRST),
        .IDX_W        (INT_IDX_W)
    ) u_int_pool (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (int_ctl),
        .i_start (r_req.interval_start),
        .i_end   (r_req.interval_end),
        .o_found (int_found),
        .o_index (int_idx)
    );

    lsra_pool #(
        .NUM_REGS     (FLOAT_REGS),
        .SEARCH_FLOOR (0),
        .IDX_W        (FLOAT_IDX_W)
    ) u_float_pool (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (float_ctl),
        .i_start (r_req.interval_start),
        .i_end   (r_req.interval_end),
        .o_found (float_found),
        .o_index (float_idx)
    );

    // Callee-saved usage: set the bit of an integer register at or above the floor.
    always_comb begin
        n_callee = r_callee;
        for (int k = 0; k < MASK_W; k++) begin
            if (int_found && (INT_CALLEE_FIRST + k < INT_REGS)
                    && (int'(int_idx) == INT_CALLEE_FIRST + k)) begin
                n_callee[k] = 1'b1;
            end
        end
    end

    // Response and spill counter for the held request.
    always_comb begin
        n_rsp   = '0;
        n_spill = r_spill;
        if (r_req.action == ACTION_CLEAR) begin
            n_rsp.callee_saved_mask = r_callee;
            n_rsp.spill_total       = r_spill;
        end else begin
            n_rsp.float_pool = r_req.is_float;
            if (float_found) begin
                n_rsp.in_register    = 1'b1;
                n_rsp.location_index = LOC_W'(float_idx);
            end else if (int_found) begin
                n_rsp.in_register    = 1'b1;
                n_rsp.location_index = LOC_W'(int_idx);
            end else if (r_spill < SPILL_W'(SPILL_SLOTS)) begin
                n_rsp.location_index = r_spill[LOC_W-1:0];
                n_spill              = r_spill + SPILL_W'(1);
            end else begin
                n_rsp.spill_overflow = 1'b1;
            end
            n_rsp.callee_saved_mask = n_callee;
            n_rsp.spill_total       = n_spill;
        end
    end

    // Per-function totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_callee <= '0;
            r_spill  <= '0;
        end else if (is_clear) begin
            r_callee <= '0;
            r_spill  <= '0;
        end else if (is_alloc) begin
            r_callee <= n_callee;
            r_spill  <= n_spill;
        end
    end

    // Response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_vld <= 1'b0;
        end else if (proc_fire) begin
            r_rsp_vld <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_vld;
    assign o_rsp       = r_rsp;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Linear scan register assignment testbench
// Sends live intervals and clear requests to the block. Intervals follow
// sorted function bodies, with some out-of-order noise mixed in. An in-bench
// allocator predicts each placement, and every response is checked field by
// field, in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import lsra_pkg::*;

    localparam int NUM_INT      = DEF_INT_REGS;
    localparam int CALLEE_FLOOR = DEF_INT_CALLEE_FIRST;
    localparam int NUM_FLOAT    = DEF_FLOAT_REGS;
    localparam int POS_MAX      = 32767;
    localparam int IDLE_LIMIT   = 2000;

    // Receiver stall patterns.
    typedef enum int {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_SELDOM,
        RX_EVERY_THIRD
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_ready;
    t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_ready;
    t_rsp o_rsp;

    // Allocator state kept by the bench.
    logic [NUM_INT-1:0]          busy_int;
    logic [NUM_FLOAT-1:0]        busy_float;
    logic signed [POS_W-1:0]     holder_end_int [NUM_INT];
    logic signed [POS_W-1:0]     holder_end_float [NUM_FLOAT];
    logic [MASK_W-1:0]           callee_used;
    logic [SPILL_W-1:0]          spill_count;

    t_rsp expected_placements[$];
    int   mismatch_count = 0;
    int   burst_left = 0;
    int   idle_cycles = 0;

    linear_scan_register_assign #(
        .INT_REGS        (NUM_INT),
        .INT_CALLEE_FIRST(CALLEE_FLOOR),
        .FLOAT_REGS      (NUM_FLOAT)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .o_rsp      (o_rsp)
    );

    // Clock with a 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Works out the placement of one request and advances the allocator state.
    function automatic t_rsp place_interval(input t_req r);
        t_rsp res;
        int   pick;
        int   lo;
        res  = '0;
        pick = -1;
        if (r.action == ACTION_CLEAR) begin
            res.callee_saved_mask = callee_used;
            res.spill_total       = spill_count;
            busy_int    = '0;
            busy_float  = '0;
            callee_used = '0;
            spill_count = '0;
            return res;
        end
        // Release every holder whose end lies strictly before the new start.
        for (int k = 0; k < NUM_INT; k++)
            if (busy_int[k] && holder_end_int[k] < $signed(r.interval_start))
                busy_int[k] = 1'b0;
        for (int k = 0; k < NUM_FLOAT; k++)
            if (busy_float[k] && holder_end_float[k] < $signed(r.interval_start))
                busy_float[k] = 1'b0;
        // Lowest free register; float values spanning a call always spill.
        if (r.is_float) begin
            if (!r.spans_call)
                for (int k = NUM_FLOAT - 1; k >= 0; k--)
                    if (!busy_float[k]) pick = k;
        end else begin
            lo = r.spans_call ? CALLEE_FLOOR : 0;
            for (int k = NUM_INT - 1; k >= lo; k--)
                if (!busy_int[k]) pick = k;
        end
        res.float_pool = r.is_float;
        if (pick >= 0) begin
            res.in_register    = 1'b1;
            res.location_index = pick[LOC_W-1:0];
            if (r.is_float) begin
                busy_float[pick]       = 1'b1;
                holder_end_float[pick] = $signed(r.interval_end);
            end else begin
                busy_int[pick]       = 1'b1;
                holder_end_int[pick] = $signed(r.interval_end);
                if (pick >= CALLEE_FLOOR && pick - CALLEE_FLOOR < MASK_W)
                    callee_used[pick - CALLEE_FLOOR] = 1'b1;
            end
        end else if (spill_count < SPILL_SLOTS) begin
            res.location_index = spill_count[LOC_W-1:0];
            spill_count        = spill_count + 1'b1;
        end else begin
            res.spill_overflow = 1'b1;
        end
        res.callee_saved_mask = callee_used;
        res.spill_total       = spill_count;
        return res;
    endfunction

    function automatic t_req make_interval(input int s, input int e, input logic fl,
                                           input logic call);
        t_req r;
        r.action         = ACTION_ALLOCATE;
        r.interval_start = s[POS_W-1:0];
        r.interval_end   = e[POS_W-1:0];
        r.is_float       = fl;
        r.spans_call     = call;
        return r;
    endfunction

    // A clear request; its interval fields are don't-care, so they are random.
    function automatic t_req make_clear();
        t_req r;
        r                = '0;
        r.action         = ACTION_CLEAR;
        r.interval_start = POS_W'($urandom);
        r.interval_end   = POS_W'($urandom);
        r.is_float       = 1'($urandom);
        r.spans_call     = 1'($urandom);
        return r;
    endfunction

    function automatic int clamp_pos(input int v);
        return (v > POS_MAX) ? POS_MAX : v;
    endfunction

    // Sends one request in bursts with random gaps, and records its placement.
    task automatic send_request(input t_req r);
        int gap;
        if (burst_left == 0) begin
            burst_left  = $urandom_range(1, 30);
            gap         = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            i_req_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        burst_left--;
        i_req       = r;
        i_req_valid = 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
        expected_placements.insert(expected_placements.size(), place_interval(r));
        @(negedge i_clk);
        i_req_valid = 1'b0;
    endtask

    task automatic wait_results_drained();
        while (expected_placements.size() != 0) @(negedge i_clk);
    endtask

    // Extremes of the fields, pool exhaustion, late ends and clears.
    task automatic test_directed_cases();
        // Parameters at start -1, one per kind.
        send_request(make_interval(-1, -1, 1'b0, 1'b0));
        send_request(make_interval(-1, POS_MAX, 1'b0, 1'b1));
        send_request(make_interval(-1, 10, 1'b1, 1'b0));
        send_request(make_interval(-1, 10, 1'b1, 1'b1));
        // Fill the callee-saved part until a call-spanning value spills.
        repeat (5) send_request(make_interval(0, POS_MAX, 1'b0, 1'b1));
        // Low registers, then a spill with every integer register held.
        send_request(make_interval(1, 5, 1'b0, 1'b0));
        send_request(make_interval(1, 5, 1'b0, 1'b0));
        send_request(make_interval(2, 3, 1'b0, 1'b0));
        // End before start: held until a start past that end.
        send_request(make_interval(100, 50, 1'b0, 1'b0));
        send_request(make_interval(100, 60, 1'b1, 1'b0));
        send_request(make_interval(101, 200, 1'b0, 1'b0));
        send_request(make_interval(POS_MAX, POS_MAX, 1'b0, 1'b0));
        send_request(make_interval(POS_MAX, POS_MAX, 1'b1, 1'b0));
        // Clear a busy function, then clear an empty one.
        send_request(make_clear());
        send_request(make_clear());
        send_request(make_interval(-1, -1, 1'b1, 1'b1));
        send_request(make_clear());
    endtask

    // Sorted function bodies with random content, some noise, and a clear each.
    task automatic test_random_functions(input int budget);
        int   sent;
        int   fn_count;
        int   len;
        int   params;
        int   pos;
        int   s;
        int   e;
        t_req r;
        sent     = 0;
        fn_count = 0;
        while (sent < budget) begin
            len    = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 25);
            pos    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32000)
                                                 : $urandom_range(0, 100);
            params = $urandom_range(0, 3);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 19) == 0) begin
                    // Out of order, or ending before its start.
                    r = make_interval(int'($urandom_range(0, POS_MAX + 1)) - 1,
                                      int'($urandom_range(0, POS_MAX + 1)) - 1,
                                      1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1)));
                end else begin
                    if (k >= params)
                        pos = clamp_pos(pos + $urandom_range(0, 5));
                    s = (k < params) ? -1 : pos;
                    e = ($urandom_range(0, 9) == 0) ? POS_MAX
                                                    : clamp_pos(s + $urandom_range(0, 50));
                    r = make_interval(s, e, 1'($urandom_range(0, 1)),
                                      $urandom_range(0, 3) == 0);
                end
                send_request(r);
            end
            send_request(make_clear());
            sent += len + 1;
            fn_count++;
            // Now and then let every response come back before the next function.
            if (fn_count % 4 == 0)
                wait_results_drained();
        end
    endtask

    // One long function with long-lived values, run past the last spill slot.
    task automatic test_spill_saturation(input int len);
        int pos;
        int e;
        pos = -1;
        for (int k = 0; k < len; k++) begin
            if (k > 0 && $urandom_range(0, 3) == 0)
                pos = clamp_pos(pos + $urandom_range(0, 3));
            e = ($urandom_range(0, 9) == 0) ? clamp_pos(pos + $urandom_range(0, 20))
                                            : POS_MAX;
            send_request(make_interval(pos, e, 1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1))));
        end
        send_request(make_clear());
    endtask

    // Main sequence.
    initial begin
        i_rst_n     = 1'b0;
        i_req_valid = 1'b0;
        i_req       = '0;
        busy_int    = '0;
        busy_float  = '0;
        callee_used = '0;
        spill_count = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_random_functions(360);
        test_spill_saturation(1060);

        wait_results_drained();
        repeat (4) @(negedge i_clk);
        if (mismatch_count == 0 && expected_placements.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Response side stalls on its own changing pattern.
    initial begin : rsp_stall_pattern
        t_rx_mode mode;
        int       hold;
        int       tick;
        i_rsp_ready = 1'b0;
        tick        = 0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            hold = $urandom_range(20, 200);
            repeat (hold) begin
                @(negedge i_clk);
                tick++;
                case (mode)
                    RX_ALWAYS:   i_rsp_ready = 1'b1;
                    RX_MOSTLY:   i_rsp_ready = ($urandom_range(0, 3) != 0);
                    RX_SELDOM:   i_rsp_ready = ($urandom_range(0, 3) == 0);
                    default:     i_rsp_ready = (tick % 3 == 0);
                endcase
            end
        end
    end

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    // Each accepted response is compared with the oldest expected placement.
    always @(posedge i_clk) begin : check_responses
        t_rsp want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (expected_placements.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected response, expected none, actual %h", $time, o_rsp);
            end else begin
                want = expected_placements.pop_front();
                check_field("in_register", int'(want.in_register),
                            int'(o_rsp.in_register));
                check_field("location_index", int'(want.location_index),
                            int'(o_rsp.location_index));
                check_field("float_pool", int'(want.float_pool),
                            int'(o_rsp.float_pool));
                check_field("callee_saved_mask", int'(want.callee_saved_mask),
                            int'(o_rsp.callee_saved_mask));
                check_field("spill_total", int'(want.spill_total),
                            int'(o_rsp.spill_total));
                check_field("spill_overflow", int'(want.spill_overflow),
                            int'(o_rsp.spill_overflow));
            end
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

endmodule
